FILE: rtl/core/timed_channel_sequencer_core_defines.svh
// Assertion macros for the timed channel sequencer checker.
// No dependencies; included by the checker file only.
`ifndef TIMED_CHANNEL_SEQUENCER_CORE_DEFINES_SVH
`define TIMED_CHANNEL_SEQUENCER_CORE_DEFINES_SVH

`define TCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define TCS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tcs_pkg.sv
// Shared constants, codes and types of the timed channel sequencer.
// No dependencies; imported by every module of the block.
package tcs_pkg;

    localparam int C_NCH    = 4;
    localparam int C_IDX_W  = $clog2(C_NCH);
    localparam int C_CH_W   = 3;
    localparam int C_SEC_W  = 16;
    localparam int C_TPS_W  = 10;

    localparam logic [C_SEC_W-1:0] C_START_DELAY_RST = 16'd15000;
    localparam logic [C_SEC_W-1:0] C_RESET_DELAY_RST = 16'd1000;
    localparam logic [C_TPS_W-1:0] C_TPS_RST         = 10'd1000;
    localparam logic [C_CH_W-1:0]  C_IDLE_STEP       = 3'd7;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_STOP   = 3'd1;
    localparam logic [2:0] MODE_RESET  = 3'd2;
    localparam logic [2:0] MODE_LOAD   = 3'd3;
    localparam logic [2:0] MODE_PAUSE  = 3'd4;
    localparam logic [2:0] MODE_RESUME = 3'd5;
    localparam logic [2:0] MODE_ADD    = 3'd6;
    localparam logic [2:0] MODE_START  = 3'd7;

    localparam logic [3:0] ANN_NONE     = 4'd0;
    localparam logic [3:0] ANN_STOP     = 4'd1;
    localparam logic [3:0] ANN_INIT     = 4'd2;
    localparam logic [3:0] ANN_TASK     = 4'd3;
    localparam logic [3:0] ANN_PAUSED   = 4'd4;
    localparam logic [3:0] ANN_FAULT    = 4'd5;
    localparam logic [3:0] ANN_RESUMED  = 4'd6;
    localparam logic [3:0] ANN_SET      = 4'd7;
    localparam logic [3:0] ANN_FULL     = 4'd8;
    localparam logic [3:0] ANN_STARTED  = 4'd9;
    localparam logic [3:0] ANN_FINISHED = 4'd10;

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_RESET = 2'd1;
    localparam logic [1:0] PEND_START = 2'd2;

    localparam logic [1:0] REG_START_DELAY = 2'd0;
    localparam logic [1:0] REG_RESET_DELAY = 2'd1;
    localparam logic [1:0] REG_TPS         = 2'd2;

    localparam logic [1:0] OP_FAULT = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;

    typedef struct packed {
        logic hit;
        logic sec_zero;
        logic ord_zero;
    } t_slot_res;

endpackage

FILE: rtl/core/tcs_slot_unit.sv
// Per-slot test unit of the timed channel sequencer, reused for every scanned channel.
// Depends on tcs_pkg.
module tcs_slot_unit
    import tcs_pkg::*;
(
    input  logic [1:0]         i_op,
    input  logic               i_fault,
    input  logic [C_SEC_W-1:0] i_secs,
    input  logic [C_CH_W-1:0]  i_order,
    output t_slot_res          o_res
);

    logic w_sec_zero;
    logic w_ord_zero;

    assign w_sec_zero = (i_secs == '0);
    assign w_ord_zero = (i_order == '0);

    always_comb begin
        o_res.sec_zero = w_sec_zero;
        o_res.ord_zero = w_ord_zero;
        unique case (i_op)
            OP_FAULT: o_res.hit = !w_sec_zero && i_fault;
            OP_ADD:   o_res.hit = w_sec_zero;
            default:  o_res.hit = 1'b0;
        endcase
    end

endmodule

FILE: rtl/core/timed_channel_sequencer_core.sv
// Timed channel sequencer: one beat in, one result strobe out per accepted beat.
// A tick walks up to the four channels one per cycle through the shared slot unit, as do add
// and start now; busy stays high until the result strobe, when a new beat may be taken.
// The sustained rate is set by that channel walk; a new beat waits for the last result.
// Reset (synchronous, active low) gives all-open mode, idle sequence and default delays.
// The receiver cannot stall; results are never held back. Depends on tcs_pkg.
module timed_channel_sequencer_core
    import tcs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [C_SEC_W-1:0] i_cfg_data,
    input  logic [2:0]         i_mode,
    input  logic [C_NCH-1:0]   i_sensor_fault,
    input  logic [C_CH_W-1:0]  i_order_a,
    input  logic [C_CH_W-1:0]  i_order_b,
    input  logic [C_CH_W-1:0]  i_order_c,
    input  logic [C_CH_W-1:0]  i_order_d,
    input  logic [C_SEC_W-1:0] i_seconds_a,
    input  logic [C_SEC_W-1:0] i_seconds_b,
    input  logic [C_SEC_W-1:0] i_seconds_c,
    input  logic [C_SEC_W-1:0] i_seconds_d,
    input  logic [C_SEC_W-1:0] i_add_seconds,
    output logic               o_valid,
    output logic [C_NCH-1:0]   o_channel_open,
    output logic [C_CH_W-1:0]  o_active_channel,
    output logic               o_is_running,
    output logic               o_is_paused,
    output logic               o_all_open,
    output logic [C_SEC_W-1:0] o_seconds_left,
    output logic [3:0]         o_announce,
    output logic [C_CH_W-1:0]  o_fault_channel,
    output logic [C_CH_W-1:0]  o_added_slot,
    output logic               o_scan_enable
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_BEGIN = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_ADV   = 3'd4;
    localparam logic [2:0] S_PRESC = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam logic [C_IDX_W-1:0] C_LAST_IDX = C_IDX_W'(C_NCH - 1);
    localparam logic [C_CH_W-1:0]  C_NCH_CH   = C_CH_W'(C_NCH);

    logic [2:0]         r_state, n_state;
    logic [2:0]         r_ret, n_ret;
    logic [C_IDX_W-1:0] r_idx, n_idx;
    logic [2:0]         r_mode, n_mode;
    logic [C_NCH-1:0]   r_faults, n_faults;
    logic [C_CH_W-1:0]  r_ld_order [C_NCH];
    logic [C_CH_W-1:0]  n_ld_order [C_NCH];
    logic [C_SEC_W-1:0] r_ld_secs [C_NCH];
    logic [C_SEC_W-1:0] n_ld_secs [C_NCH];
    logic [C_SEC_W-1:0] r_add_secs, n_add_secs;

    logic [C_SEC_W-1:0] r_start_delay, n_start_delay;
    logic [C_SEC_W-1:0] r_reset_delay, n_reset_delay;
    logic [C_TPS_W-1:0] r_tps, n_tps;

    logic               r_running, n_running;
    logic               r_paused, n_paused;
    logic               r_all_open, n_all_open;
    logic [C_CH_W-1:0]  r_step, n_step;
    logic [C_CH_W-1:0]  r_step_order [C_NCH];
    logic [C_CH_W-1:0]  n_step_order [C_NCH];
    logic [C_SEC_W-1:0] r_chan_secs [C_NCH];
    logic [C_SEC_W-1:0] n_chan_secs [C_NCH];
    logic [C_SEC_W-1:0] r_countdown, n_countdown;
    logic [1:0]         r_pend_kind, n_pend_kind;
    logic [C_SEC_W-1:0] r_pend_ms, n_pend_ms;
    logic [C_TPS_W-1:0] r_psc, n_psc;

    logic [3:0]         r_ann, n_ann;
    logic [C_CH_W-1:0]  r_fault_ch, n_fault_ch;
    logic [C_CH_W-1:0]  r_added, n_added;

    logic               r_valid, n_valid;
    logic [C_NCH-1:0]   r_out_open, n_out_open;
    logic [C_CH_W-1:0]  r_out_active, n_out_active;
    logic               r_out_running, n_out_running;
    logic               r_out_paused, n_out_paused;
    logic               r_out_all_open, n_out_all_open;
    logic [C_SEC_W-1:0] r_out_secs, n_out_secs;
    logic [3:0]         r_out_ann, n_out_ann;
    logic [C_CH_W-1:0]  r_out_fault, n_out_fault;
    logic [C_CH_W-1:0]  r_out_added, n_out_added;
    logic               r_out_scan, n_out_scan;

    logic [C_IDX_W-1:0] w_ord_addr;
    logic [C_CH_W-1:0]  w_ord_rd;
    logic [C_CH_W-1:0]  w_cur_ch;
    logic [C_IDX_W-1:0] w_sec_addr;
    logic [C_SEC_W-1:0] w_sec_rd;
    logic [1:0]         w_op;
    t_slot_res          w_slot;
    logic               w_live;
    logic [C_SEC_W-1:0] w_pend_dec;
    logic [C_TPS_W-1:0] w_tps_eff;
    logic [C_TPS_W:0]   w_psc_inc;
    logic [C_CH_W-1:0]  w_slot_ch;

    assign w_ord_addr = (r_state == S_SCAN) ? r_idx : r_step[C_IDX_W-1:0];
    assign w_ord_rd   = r_step_order[w_ord_addr];
    assign w_cur_ch   = (r_step < C_NCH_CH && w_ord_rd != '0 && w_ord_rd <= C_NCH_CH)
                        ? w_ord_rd : '0;
    assign w_sec_addr = (r_state == S_BEGIN) ? C_IDX_W'(w_cur_ch - 3'd1) : r_idx;
    assign w_sec_rd   = r_chan_secs[w_sec_addr];
    assign w_op       = (r_mode == MODE_TICK) ? OP_FAULT :
                        (r_mode == MODE_ADD)  ? OP_ADD : OP_FILL;
    assign w_live     = r_running && !r_paused;
    assign w_pend_dec = (r_pend_ms != '0) ? r_pend_ms - 1'b1 : '0;
    assign w_tps_eff  = (r_tps == '0) ? C_TPS_W'(1) : r_tps;
    assign w_psc_inc  = {1'b0, r_psc} + 1'b1;
    assign w_slot_ch  = C_CH_W'(r_idx) + 3'd1;

    tcs_slot_unit u_slot (
        .i_op    (w_op),
        .i_fault (r_faults[r_idx]),
        .i_secs  (w_sec_rd),
        .i_order (w_ord_rd),
        .o_res   (w_slot)
    );

    always_comb begin
        n_state       = r_state;
        n_ret         = r_ret;
        n_idx         = r_idx;
        n_mode        = r_mode;
        n_faults      = r_faults;
        n_ld_order    = r_ld_order;
        n_ld_secs     = r_ld_secs;
        n_add_secs    = r_add_secs;
        n_start_delay = r_start_delay;
        n_reset_delay = r_reset_delay;
        n_tps         = r_tps;
        n_running     = r_running;
        n_paused      = r_paused;
        n_all_open    = r_all_open;
        n_step        = r_step;
        n_step_order  = r_step_order;
        n_chan_secs   = r_chan_secs;
        n_countdown   = r_countdown;
        n_pend_kind   = r_pend_kind;
        n_pend_ms     = r_pend_ms;
        n_psc         = r_psc;
        n_ann         = r_ann;
        n_fault_ch    = r_fault_ch;
        n_added       = r_added;
        n_valid       = (r_state == S_OUT);
        n_out_open    = r_out_open;
        n_out_active  = r_out_active;
        n_out_running = r_out_running;
        n_out_paused  = r_out_paused;
        n_out_all_open = r_out_all_open;
        n_out_secs    = r_out_secs;
        n_out_ann     = r_out_ann;
        n_out_fault   = r_out_fault;
        n_out_added   = r_out_added;
        n_out_scan    = r_out_scan;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_START_DELAY: n_start_delay = i_cfg_data;
                REG_RESET_DELAY: n_reset_delay = i_cfg_data;
                REG_TPS:         n_tps = i_cfg_data[C_TPS_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state       = S_EXEC;
                    n_mode        = i_mode;
                    n_faults      = i_sensor_fault;
                    n_ld_order[0] = i_order_a;
                    n_ld_order[1] = i_order_b;
                    n_ld_order[2] = i_order_c;
                    n_ld_order[3] = i_order_d;
                    n_ld_secs[0]  = i_seconds_a;
                    n_ld_secs[1]  = i_seconds_b;
                    n_ld_secs[2]  = i_seconds_c;
                    n_ld_secs[3]  = i_seconds_d;
                    n_add_secs    = i_add_seconds;
                    n_ann         = ANN_NONE;
                    n_fault_ch    = '0;
                    n_added       = '0;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
                n_idx   = '0;
                unique case (r_mode)
                    MODE_TICK: begin
                        n_state = S_SCAN;
                        if (r_pend_kind != PEND_NONE) begin
                            n_pend_ms = w_pend_dec;
                            if (w_pend_dec == '0) begin
                                n_pend_kind = PEND_NONE;
                                if (r_pend_kind == PEND_RESET) begin
                                    n_running   = 1'b0;
                                    n_paused    = 1'b0;
                                    n_countdown = '0;
                                    n_step      = C_IDLE_STEP;
                                    n_all_open  = 1'b1;
                                end else if (r_pend_kind == PEND_START) begin
                                    n_step    = '0;
                                    n_running = 1'b1;
                                    n_paused  = 1'b0;
                                    n_ann     = ANN_STARTED;
                                    n_ret     = S_SCAN;
                                    n_state   = S_BEGIN;
                                end
                            end
                        end
                    end
                    MODE_STOP: begin
                        n_all_open  = 1'b0;
                        n_running   = 1'b0;
                        n_paused    = 1'b0;
                        n_countdown = '0;
                        n_step      = C_IDLE_STEP;
                        n_pend_kind = PEND_NONE;
                        n_ann       = ANN_STOP;
                    end
                    MODE_RESET: begin
                        n_pend_kind = PEND_RESET;
                        n_pend_ms   = r_reset_delay;
                        n_ann       = ANN_INIT;
                    end
                    MODE_LOAD: begin
                        n_all_open  = 1'b0;
                        n_running   = 1'b0;
                        n_paused    = 1'b0;
                        n_countdown = '0;
                        n_step      = C_IDLE_STEP;
                        for (int i = 0; i < C_NCH; i++) begin
                            n_step_order[i] = (r_ld_order[i] <= C_NCH_CH) ? r_ld_order[i] : '0;
                            n_chan_secs[i]  = r_ld_secs[i];
                        end
                        n_pend_kind = PEND_START;
                        n_pend_ms   = r_start_delay;
                        n_ann       = ANN_TASK;
                    end
                    MODE_PAUSE: begin
                        if (w_live) begin
                            n_paused = 1'b1;
                            n_ann    = ANN_PAUSED;
                        end
                    end
                    MODE_RESUME: begin
                        if (r_running && r_paused) begin
                            n_paused = 1'b0;
                            n_ann    = ANN_RESUMED;
                        end
                    end
                    MODE_ADD: begin
                        n_ann   = ANN_FULL;
                        n_state = S_SCAN;
                    end
                    MODE_START: begin
                        n_all_open = 1'b0;
                        n_ann      = ANN_STARTED;
                        n_state    = S_SCAN;
                    end
                    default: ;
                endcase
            end
            S_BEGIN: begin
                n_countdown = (w_cur_ch != '0) ? w_sec_rd : '0;
                n_state     = r_ret;
            end
            S_SCAN: begin
                unique case (w_op)
                    OP_FAULT: begin
                        if (!w_live) begin
                            n_state = S_ADV;
                        end else if (w_slot.hit) begin
                            n_paused   = 1'b1;
                            n_ann      = ANN_FAULT;
                            n_fault_ch = w_slot_ch;
                            n_state    = S_ADV;
                        end else if (r_idx == C_LAST_IDX) begin
                            n_state = S_ADV;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    OP_ADD: begin
                        if (w_slot.hit) begin
                            n_chan_secs[r_idx] = r_add_secs;
                            if (w_slot.ord_zero) begin
                                n_step_order[r_idx] = w_slot_ch;
                            end
                            n_added = w_slot_ch;
                            n_ann   = ANN_SET;
                            n_state = S_OUT;
                        end else if (r_idx == C_LAST_IDX) begin
                            n_state = S_OUT;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    default: begin
                        if (w_slot.ord_zero) begin
                            n_step_order[r_idx] = w_slot_ch;
                        end
                        if (r_idx == C_LAST_IDX) begin
                            n_step    = '0;
                            n_running = 1'b1;
                            n_paused  = 1'b0;
                            n_ret     = S_OUT;
                            n_state   = S_BEGIN;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                endcase
            end
            S_ADV: begin
                n_state = S_PRESC;
                if (w_live && r_countdown == '0) begin
                    if (r_step + 1'b1 >= C_NCH_CH) begin
                        n_running = 1'b0;
                        n_step    = C_IDLE_STEP;
                        n_ann     = ANN_FINISHED;
                    end else begin
                        n_step  = r_step + 1'b1;
                        n_ret   = S_PRESC;
                        n_state = S_BEGIN;
                    end
                end
            end
            S_PRESC: begin
                n_state = S_OUT;
                if (w_psc_inc >= {1'b0, w_tps_eff}) begin
                    n_psc = '0;
                    if (w_live && r_countdown != '0) begin
                        n_countdown = r_countdown - 1'b1;
                    end
                end else begin
                    n_psc = w_psc_inc[C_TPS_W-1:0];
                end
            end
            S_OUT: begin
                n_state       = S_IDLE;
                n_out_active  = r_running ? w_cur_ch : '0;
                n_out_open    = '0;
                if (!r_paused) begin
                    if (r_all_open) begin
                        n_out_open = '1;
                    end else if (r_running && w_cur_ch != '0) begin
                        n_out_open = C_NCH'(1) << (w_cur_ch - 3'd1);
                    end
                end
                n_out_running  = r_running;
                n_out_paused   = r_paused;
                n_out_all_open = r_all_open;
                n_out_secs     = r_countdown;
                n_out_ann      = r_ann;
                n_out_fault    = r_fault_ch;
                n_out_added    = r_added;
                n_out_scan     = w_live;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= 1'b0;
            r_start_delay <= C_START_DELAY_RST;
            r_reset_delay <= C_RESET_DELAY_RST;
            r_tps         <= C_TPS_RST;
            r_running     <= 1'b0;
            r_paused      <= 1'b0;
            r_all_open    <= 1'b1;
            r_step        <= C_IDLE_STEP;
            r_countdown   <= '0;
            r_pend_kind   <= PEND_NONE;
            r_pend_ms     <= '0;
            r_psc         <= '0;
            for (int i = 0; i < C_NCH; i++) begin
                r_step_order[i] <= '0;
                r_chan_secs[i]  <= '0;
            end
        end else begin
            r_state       <= n_state;
            r_valid       <= n_valid;
            r_start_delay <= n_start_delay;
            r_reset_delay <= n_reset_delay;
            r_tps         <= n_tps;
            r_running     <= n_running;
            r_paused      <= n_paused;
            r_all_open    <= n_all_open;
            r_step        <= n_step;
            r_countdown   <= n_countdown;
            r_pend_kind   <= n_pend_kind;
            r_pend_ms     <= n_pend_ms;
            r_psc         <= n_psc;
            r_step_order  <= n_step_order;
            r_chan_secs   <= n_chan_secs;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret          <= n_ret;
        r_idx          <= n_idx;
        r_mode         <= n_mode;
        r_faults       <= n_faults;
        r_ld_order     <= n_ld_order;
        r_ld_secs      <= n_ld_secs;
        r_add_secs     <= n_add_secs;
        r_ann          <= n_ann;
        r_fault_ch     <= n_fault_ch;
        r_added        <= n_added;
        r_out_open     <= n_out_open;
        r_out_active   <= n_out_active;
        r_out_running  <= n_out_running;
        r_out_paused   <= n_out_paused;
        r_out_all_open <= n_out_all_open;
        r_out_secs     <= n_out_secs;
        r_out_ann      <= n_out_ann;
        r_out_fault    <= n_out_fault;
        r_out_added    <= n_out_added;
        r_out_scan     <= n_out_scan;
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_channel_open   = r_out_open;
    assign o_active_channel = r_out_active;
    assign o_is_running     = r_out_running;
    assign o_is_paused      = r_out_paused;
    assign o_all_open       = r_out_all_open;
    assign o_seconds_left   = r_out_secs;
    assign o_announce       = r_out_ann;
    assign o_fault_channel  = r_out_fault;
    assign o_added_slot     = r_out_added;
    assign o_scan_enable    = r_out_scan;

endmodule

FILE: rtl/core/tcs_checker.sv
// Port-level checker of the timed channel sequencer, bound to the top level.
// Depends on tcs_pkg and timed_channel_sequencer_core_defines.svh.
`include "timed_channel_sequencer_core_defines.svh"

module tcs_checker
    import tcs_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              o_valid,
    input logic [C_NCH-1:0]  o_channel_open,
    input logic [C_CH_W-1:0] o_active_channel,
    input logic              o_is_running,
    input logic              o_is_paused,
    input logic              o_scan_enable
);

    `TCS_ASSERT_NXT(a_accept_busy, i_start && !o_busy, o_busy, "accepted beat did not raise busy")
    `TCS_ASSERT_NXT(a_single_strobe, o_valid, !o_valid, "result strobe longer than one cycle")
    `TCS_ASSERT_IMP(a_strobe_idle, o_valid, !o_busy, "result strobe while still busy")
    `TCS_ASSERT_IMP(a_pause_closed, o_valid && o_is_paused, o_channel_open == '0, "valve open while paused")
    `TCS_ASSERT_IMP(a_idle_quiet, o_valid && !o_is_running, o_active_channel == '0 && !o_scan_enable, "active channel while stopped")

endmodule

bind timed_channel_sequencer_core tcs_checker u_tcs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_start          (i_start),
    .o_busy           (o_busy),
    .o_valid          (o_valid),
    .o_channel_open   (o_channel_open),
    .o_active_channel (o_active_channel),
    .o_is_running     (o_is_running),
    .o_is_paused      (o_is_paused),
    .o_scan_enable    (o_scan_enable)
);
